// ===== rtl/tgcv_pkg.sv =====
// Package for the two-group coefficient-of-variation row filter.
// Holds widths, state codes, the command struct and the threshold reset value.
// No dependencies; used by every module of the block.
package tgcv_pkg;

   localparam int MAX_COLUMNS = 1024;
   localparam int VALUE_W     = 32;
   localparam int TAG_W       = 2;
   localparam int CELL_W      = $clog2(MAX_COLUMNS + 1);
   localparam int TOTAL_W     = CELL_W + 1;
   localparam int SUM_W       = VALUE_W + $clog2(MAX_COLUMNS);
   localparam int PROD_W      = SUM_W + CELL_W;
   localparam int DEN_W       = PROD_W + 1;
   localparam int Q_W         = 16;
   localparam int CV_W        = Q_W + 1;
   localparam int DIV_CNT_W   = $clog2(Q_W);
   localparam int RSP_DATA_W  = 24;

   localparam logic [CV_W-1:0]   CV_ONE            = CV_W'(1 << Q_W);
   localparam logic [CV_W-1:0]   CV_THRESHOLD_INIT = CV_W'(62259);

   localparam logic [TAG_W-1:0]  TAG_FIRST  = TAG_W'(0);
   localparam logic [TAG_W-1:0]  TAG_SECOND = TAG_W'(1);

   localparam logic [2:0] ST_ACCUM = 3'd0;
   localparam logic [2:0] ST_MUL   = 3'd1;
   localparam logic [2:0] ST_SUB   = 3'd2;
   localparam logic [2:0] ST_DIV   = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   typedef struct packed {
      logic accept;
      logic mul_load;
      logic sub_load;
      logic div_step;
      logic out_load;
   } tgcv_cmd_type;

endpackage

// ===== rtl/two_group_cv_row_filter_unit.sv =====
// Two-group coefficient-of-variation row filter, top level.
// Streaming channels: req_ carries cells (tdata value, tuser group, tlast row end);
// rsp_ carries one result per row. A single threshold register is written on csr_.
// Cells are taken one per cycle while a row streams in. The row-end transfer starts
// the row computation: cross products, then subtract and add, then the restoring
// divider (one quotient bit per cycle), then the result load. req_tready is low from
// the row-end transfer until the result load. The divider loop is the longest part
// of this per-row work.
// The result register holds a result until it is taken; the next row streams in
// meanwhile, and only its row-end computation waits at the final load while an
// earlier result is stalled on rsp_tready.
// Synchronous reset clears the accumulators, drops any pending result and sets the
// threshold to 62259 (0.95 in Q16). Configuration must be written only while idle.
// Depends on tgcv_pkg, tgcv_ctrl and tgcv_datapath.
module two_group_cv_row_filter_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [tgcv_pkg::VALUE_W-1:0]    req_tdata,   // [31:0] count_value
   input  logic [tgcv_pkg::TAG_W-1:0]      req_tuser,   // [1:0] group_tag
   input  logic                            req_tlast,   // row_end
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [tgcv_pkg::RSP_DATA_W-1:0] rsp_tdata,   // [0] keep_row, [17:1] cv_value,
                                                        // [18] nonzero_test_passed, zeros
   input  logic                            csr_wr_en,
   input  logic [tgcv_pkg::CV_W-1:0]       csr_wr_data  // cv_threshold
);

   tgcv_pkg::tgcv_cmd_type         cmd;
   logic                           keep_row;
   logic [tgcv_pkg::CV_W-1:0]      cv_value;
   logic                           nonzero_test_passed;

   tgcv_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .cmd        (cmd)
   );

   tgcv_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .count_value         (req_tdata),
      .group_tag           (req_tuser),
      .row_end             (req_tlast),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .keep_row            (keep_row),
      .cv_value            (cv_value),
      .nonzero_test_passed (nonzero_test_passed)
   );

   assign rsp_tdata = {{(tgcv_pkg::RSP_DATA_W - tgcv_pkg::CV_W - 2){1'b0}},
                       nonzero_test_passed, cv_value, keep_row};

`ifndef SYNTH
   a_row_end_stalls_input: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast) |=> !req_tready)
      else $error("input accepted right after a row-end transfer");

   a_keep_needs_pass: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (!keep_row || nonzero_test_passed))
      else $error("row kept without a passed nonzero test");

   a_cv_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (cv_value <= tgcv_pkg::CV_ONE))
      else $error("coefficient of variation above one");

   a_fail_gives_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !nonzero_test_passed) |-> (cv_value == '0))
      else $error("nonzero cv for a row that failed the test");
`endif

endmodule

// ===== rtl/tgcv_ctrl.sv =====
// Controller state machine of the row filter.
// Sequences accumulation, multiply, subtract, divide and result hand-off.
// Depends on tgcv_pkg.
module tgcv_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tlast,
   output logic                  req_tready,
   input  logic                  rsp_tready,
   output logic                  rsp_tvalid,
   output tgcv_pkg::tgcv_cmd_type cmd
);

   logic [2:0]                      state_ff, state_in;
   logic [tgcv_pkg::DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic                            valid_ff, valid_in;
   logic                            out_free;

   assign out_free   = !valid_ff || rsp_tready;
   assign req_tready = (state_ff == tgcv_pkg::ST_ACCUM);
   assign rsp_tvalid = valid_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cmd.accept   = 1'b0;
      cmd.mul_load = 1'b0;
      cmd.sub_load = 1'b0;
      cmd.div_step = 1'b0;
      cmd.out_load = 1'b0;
      case (state_ff)
         tgcv_pkg::ST_ACCUM: begin
            cmd.accept = req_tvalid;
            if (req_tvalid && req_tlast) begin
               state_in = tgcv_pkg::ST_MUL;
            end
         end
         tgcv_pkg::ST_MUL: begin
            cmd.mul_load = 1'b1;
            state_in     = tgcv_pkg::ST_SUB;
         end
         tgcv_pkg::ST_SUB: begin
            cmd.sub_load = 1'b1;
            cnt_in       = '0;
            state_in     = tgcv_pkg::ST_DIV;
         end
         tgcv_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == {tgcv_pkg::DIV_CNT_W{1'b1}}) begin
               state_in = tgcv_pkg::ST_DONE;
            end
         end
         tgcv_pkg::ST_DONE: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = tgcv_pkg::ST_ACCUM;
            end
         end
         default: begin
            state_in = tgcv_pkg::ST_ACCUM;
         end
      endcase
   end

   always_comb begin
      if (cmd.out_load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tgcv_pkg::ST_ACCUM;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

endmodule

// ===== rtl/tgcv_datapath.sv =====
// Datapath of the row filter: group accumulators, cross products,
// restoring Q16 divider, threshold register and result register.
// Depends on tgcv_pkg; driven by commands from tgcv_ctrl.
module tgcv_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  tgcv_pkg::tgcv_cmd_type           cmd,
   input  logic [tgcv_pkg::VALUE_W-1:0]     count_value,
   input  logic [tgcv_pkg::TAG_W-1:0]       group_tag,
   input  logic                             row_end,
   input  logic                             csr_wr_en,
   input  logic [tgcv_pkg::CV_W-1:0]        csr_wr_data,
   output logic                             keep_row,
   output logic [tgcv_pkg::CV_W-1:0]        cv_value,
   output logic                             nonzero_test_passed
);

   localparam int SUM_W  = tgcv_pkg::SUM_W;
   localparam int CELL_W = tgcv_pkg::CELL_W;
   localparam int PROD_W = tgcv_pkg::PROD_W;
   localparam int DEN_W  = tgcv_pkg::DEN_W;
   localparam int Q_W    = tgcv_pkg::Q_W;
   localparam int CV_W   = tgcv_pkg::CV_W;

   logic [CV_W-1:0]   thr_ff;

   logic [SUM_W-1:0]  acc_s1_ff, acc_s1_in, acc_s2_ff, acc_s2_in;
   logic [CELL_W-1:0] acc_n1_ff, acc_n1_in, acc_n2_ff, acc_n2_in;
   logic [CELL_W-1:0] acc_z1_ff, acc_z1_in, acc_z2_ff, acc_z2_in;
   logic [tgcv_pkg::TOTAL_W-1:0] total;
   logic              room, nonzero;

   logic [SUM_W-1:0]  s1_ff, s2_ff;
   logic [CELL_W-1:0] n1_ff, n2_ff;
   logic              passed_ff, passed_in, empty_ff;

   logic [PROD_W-1:0] a_ff, a_in, b_ff, b_in;
   logic [PROD_W-1:0] num;
   logic [DEN_W-1:0]  den, den_ff;
   logic              ge_ff, zden_ff;

   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [DEN_W:0]    rem_shift;
   logic              rem_ge;
   logic [Q_W-1:0]    q_ff, q_in;

   logic [CV_W-1:0]   cv_in;
   logic              keep_ff, pass_out_ff;
   logic [CV_W-1:0]   cv_ff;

   assign total   = {1'b0, acc_n1_ff} + {1'b0, acc_n2_ff};
   assign room    = total < tgcv_pkg::TOTAL_W'(tgcv_pkg::MAX_COLUMNS);
   assign nonzero = (count_value != '0);

   always_comb begin
      acc_s1_in = acc_s1_ff;
      acc_s2_in = acc_s2_ff;
      acc_n1_in = acc_n1_ff;
      acc_n2_in = acc_n2_ff;
      acc_z1_in = acc_z1_ff;
      acc_z2_in = acc_z2_ff;
      if (room && group_tag == tgcv_pkg::TAG_FIRST) begin
         acc_s1_in = acc_s1_ff + SUM_W'(count_value);
         acc_n1_in = acc_n1_ff + 1'b1;
         acc_z1_in = acc_z1_ff + CELL_W'(nonzero);
      end else if (room && group_tag == tgcv_pkg::TAG_SECOND) begin
         acc_s2_in = acc_s2_ff + SUM_W'(count_value);
         acc_n2_in = acc_n2_ff + 1'b1;
         acc_z2_in = acc_z2_ff + CELL_W'(nonzero);
      end
   end

   assign passed_in = (acc_z1_in > (acc_n1_in >> 1)) || (acc_z2_in > (acc_n2_in >> 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff    <= tgcv_pkg::CV_THRESHOLD_INIT;
         acc_s1_ff <= '0;
         acc_s2_ff <= '0;
         acc_n1_ff <= '0;
         acc_n2_ff <= '0;
         acc_z1_ff <= '0;
         acc_z2_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            thr_ff <= csr_wr_data;
         end
         if (cmd.accept) begin
            if (row_end) begin
               acc_s1_ff <= '0;
               acc_s2_ff <= '0;
               acc_n1_ff <= '0;
               acc_n2_ff <= '0;
               acc_z1_ff <= '0;
               acc_z2_ff <= '0;
            end else begin
               acc_s1_ff <= acc_s1_in;
               acc_s2_ff <= acc_s2_in;
               acc_n1_ff <= acc_n1_in;
               acc_n2_ff <= acc_n2_in;
               acc_z1_ff <= acc_z1_in;
               acc_z2_ff <= acc_z2_in;
            end
         end
      end
   end

   assign a_in = PROD_W'(s1_ff) * PROD_W'(n2_ff);
   assign b_in = PROD_W'(s2_ff) * PROD_W'(n1_ff);
   assign num  = (a_ff >= b_ff) ? (a_ff - b_ff) : (b_ff - a_ff);
   assign den  = {1'b0, a_ff} + {1'b0, b_ff};

   assign rem_shift = {rem_ff, 1'b0};
   assign rem_ge    = rem_shift >= {1'b0, den_ff};
   assign rem_in    = rem_ge ? DEN_W'(rem_shift - {1'b0, den_ff}) : DEN_W'(rem_shift);
   assign q_in      = {q_ff[Q_W-2:0], rem_ge};

   always_comb begin
      if (!passed_ff) begin
         cv_in = '0;
      end else if (empty_ff) begin
         cv_in = tgcv_pkg::CV_ONE;
      end else if (zden_ff) begin
         cv_in = '0;
      end else if (ge_ff) begin
         cv_in = tgcv_pkg::CV_ONE;
      end else begin
         cv_in = {1'b0, q_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && row_end) begin
         s1_ff     <= acc_s1_in;
         s2_ff     <= acc_s2_in;
         n1_ff     <= acc_n1_in;
         n2_ff     <= acc_n2_in;
         passed_ff <= passed_in;
         empty_ff  <= (acc_n1_in == '0) || (acc_n2_in == '0);
      end
      if (cmd.mul_load) begin
         a_ff <= a_in;
         b_ff <= b_in;
      end
      if (cmd.sub_load) begin
         den_ff  <= den;
         rem_ff  <= DEN_W'(num);
         q_ff    <= '0;
         ge_ff   <= DEN_W'(num) >= den;
         zden_ff <= (den == '0);
      end
      if (cmd.div_step) begin
         rem_ff <= rem_in;
         q_ff   <= q_in;
      end
      if (cmd.out_load) begin
         cv_ff       <= cv_in;
         keep_ff     <= passed_ff && (cv_in >= thr_ff);
         pass_out_ff <= passed_ff;
      end
   end

   assign keep_row            = keep_ff;
   assign cv_value            = cv_ff;
   assign nonzero_test_passed = pass_out_ff;

endmodule

// ===== verif/two_group_cv_row_filter_unit_test.sv =====
// Self-checking testbench for two_group_cv_row_filter_unit: streams tagged count cells,
// predicts each row verdict (nonzero test, Q16 CV of the two means, keep flag) and checks it.
// Depends on tgcv_pkg and the RTL of the block only.
module two_group_cv_row_filter_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import tgcv_pkg::*;

   localparam logic [TAG_W-1:0] TAG_IGNORED = TAG_W'(2);
   localparam logic [TAG_W-1:0] TAG_SPARE   = TAG_W'(3);
   localparam int ROW_LATENCY     = 19;
   localparam int RSP_HOLD_CYCLES = 600;

   typedef struct packed {
      logic [VALUE_W-1:0] count_value;
      logic [TAG_W-1:0]   group_tag;
      logic               row_end;
   } cell_type;

   typedef struct packed {
      logic            keep_row;
      logic [CV_W-1:0] cv_value;
      logic            nonzero_passed;
   } verdict_type;

   typedef enum int {
      SHAPE_MIXED,
      SHAPE_FIRST_ONLY,
      SHAPE_SECOND_ONLY,
      SHAPE_EQUAL,
      SHAPE_NOISY
   } row_shape_type;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [VALUE_W-1:0]    req_tdata   = '0;
   logic [TAG_W-1:0]      req_tuser   = '0;
   logic                  req_tlast   = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_wr_en   = 1'b0;
   logic [CV_W-1:0]       csr_wr_data = '0;

   cell_type    pending_cells[$];
   verdict_type expected_verdicts[$];
   cell_type    cur_cell;

   logic [CV_W-1:0]   row_threshold = CV_THRESHOLD_INIT;
   logic [SUM_W-1:0]  sum_g0 = '0, sum_g1 = '0;
   logic [CELL_W-1:0] cells_g0 = '0, cells_g1 = '0;
   logic [CELL_W-1:0] nonzero_g0 = '0, nonzero_g1 = '0;

   logic no_idle        = 1'b0;
   logic hold_rsp       = 1'b0;
   logic pressure_armed = 1'b0;
   int   send_gap = 0, recv_gap = 0;
   int   mismatches = 0, verdicts_checked = 0, cells_sent = 0, rows_sent = 0;
   int   rows_kept = 0, rows_failed_test = 0, settings_used = 1;

   two_group_cv_row_filter_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #4 clock = ~clock;

   task automatic account_cell(input cell_type c);
      logic                 room;
      logic                 passed;
      logic [PROD_W-1:0]    cross_a, cross_b;
      logic [DEN_W-1:0]     spread, total;
      logic [DEN_W+Q_W-1:0] scaled;
      logic [CV_W-1:0]      cv;
      verdict_type          v;
      cells_sent++;
      room = (int'(cells_g0) + int'(cells_g1)) < MAX_COLUMNS;
      if (room && c.group_tag == TAG_FIRST) begin
         sum_g0 += SUM_W'(c.count_value);
         cells_g0++;
         if (c.count_value != '0) nonzero_g0++;
      end else if (room && c.group_tag == TAG_SECOND) begin
         sum_g1 += SUM_W'(c.count_value);
         cells_g1++;
         if (c.count_value != '0) nonzero_g1++;
      end
      if (!c.row_end) return;
      passed = (nonzero_g0 > (cells_g0 >> 1)) || (nonzero_g1 > (cells_g1 >> 1));
      cv = '0;
      if (passed) begin
         if (cells_g0 == '0 || cells_g1 == '0) begin
            cv = CV_ONE;
         end else begin
            cross_a = PROD_W'(sum_g0) * PROD_W'(cells_g1);
            cross_b = PROD_W'(sum_g1) * PROD_W'(cells_g0);
            spread  = (cross_a >= cross_b) ? DEN_W'(cross_a - cross_b)
                                           : DEN_W'(cross_b - cross_a);
            total   = DEN_W'(cross_a) + DEN_W'(cross_b);
            if (total == '0) begin
               cv = '0;
            end else if (spread >= total) begin
               cv = CV_ONE;
            end else begin
               scaled = {spread, Q_W'(0)} / (DEN_W+Q_W)'(total);
               cv = CV_W'(scaled);
            end
         end
      end
      v.keep_row       = passed && (cv >= row_threshold);
      v.cv_value       = cv;
      v.nonzero_passed = passed;
      expected_verdicts.insert(expected_verdicts.size(), v);
      rows_sent++;
      if (v.keep_row) rows_kept++;
      if (!passed) rows_failed_test++;
      sum_g0 = '0; cells_g0 = '0; nonzero_g0 = '0;
      sum_g1 = '0; cells_g1 = '0; nonzero_g1 = '0;
   endtask

   always @(posedge clock) begin : drive_cells
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) account_cell(cur_cell);
         if (!(req_tvalid && !req_tready)) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (!no_idle && $urandom_range(0, 9) == 0) begin
               send_gap = $urandom_range(1, 13) - 1;
               req_tvalid <= 1'b0;
            end else if (pending_cells.size() != 0) begin
               cur_cell = pending_cells.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= cur_cell.count_value;
               req_tuser  <= cur_cell.group_tag;
               req_tlast  <= cur_cell.row_end;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : watch_verdicts
      verdict_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.keep_row       = rsp_tdata[0];
            got.cv_value       = rsp_tdata[CV_W:1];
            got.nonzero_passed = rsp_tdata[CV_W+1];
            if (expected_verdicts.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Result transfer with no row pending: keep=%0d cv=%0d passed=%0d",
                           got.keep_row, got.cv_value, got.nonzero_passed);
            end else begin
               want = expected_verdicts.pop_front();
               if (want.keep_row != got.keep_row || want.cv_value != got.cv_value ||
                   want.nonzero_passed != got.nonzero_passed) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("Row verdict mismatch: expected keep=%0d cv=%0d passed=%0d, %s",
                              want.keep_row, want.cv_value, want.nonzero_passed,
                              $sformatf("got keep=%0d cv=%0d passed=%0d", got.keep_row,
                                        got.cv_value, got.nonzero_passed));
               end else begin
                  verdicts_checked++;
               end
            end
         end
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_tready <= 1'b0;
         end else if (!no_idle && $urandom_range(0, 5) == 0) begin
            recv_gap = $urandom_range(1, 13) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin : rsp_hold_off
      wait (pressure_armed);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (RSP_HOLD_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   initial begin : run_limit
      #4_000_000;
      $display("== FAIL ==");
      $finish;
   end

   task automatic push_cell(input logic [VALUE_W-1:0] value, input logic [TAG_W-1:0] tag,
                            input logic row_end);
      cell_type c;
      c.count_value = value;
      c.group_tag   = tag;
      c.row_end     = row_end;
      pending_cells.insert(pending_cells.size(), c);
   endtask

   function automatic logic [VALUE_W-1:0] pick_value(input int zero_pct);
      int unsigned sel;
      sel = $urandom_range(0, 3);
      if ($urandom_range(0, 99) < zero_pct) return '0;
      case (sel)
         0: return VALUE_W'($urandom_range(1, 15));
         1: return '1;
         default: return VALUE_W'($urandom());
      endcase
   endfunction

   task automatic push_random_rows(input int budget);
      int                 len, zero_pct, i;
      row_shape_type      shape;
      logic [VALUE_W-1:0] same;
      logic [TAG_W-1:0]   tag;
      while (budget > 0) begin
         len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
         shape = row_shape_type'($urandom_range(0, 4));
         zero_pct = $urandom_range(0, 100);
         same = pick_value(zero_pct / 2);
         for (i = 0; i < len; i++) begin
            case (shape)
               SHAPE_FIRST_ONLY:  tag = TAG_FIRST;
               SHAPE_SECOND_ONLY: tag = TAG_SECOND;
               SHAPE_NOISY: begin
                  if ($urandom_range(0, 9) < 3)
                     tag = $urandom_range(0, 1) ? TAG_IGNORED : TAG_SPARE;
                  else
                     tag = $urandom_range(0, 1) ? TAG_SECOND : TAG_FIRST;
               end
               default: tag = $urandom_range(0, 1) ? TAG_SECOND : TAG_FIRST;
            endcase
            push_cell((shape == SHAPE_EQUAL) ? same : pick_value(zero_pct), tag, i == len - 1);
         end
         budget -= len;
      end
   endtask

   task automatic drain_rows();
      while (pending_cells.size() != 0 || req_tvalid || expected_verdicts.size() != 0)
         @(posedge clock);
      repeat (ROW_LATENCY + 8) @(posedge clock);
   endtask

   task automatic set_threshold(input logic [CV_W-1:0] level);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= level;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      row_threshold = level;
      settings_used++;
   endtask

   initial begin : sequence_rows
      int i;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed rows at the reset threshold.
      push_cell('1, TAG_FIRST, 1'b0);
      push_cell(VALUE_W'(1), TAG_SECOND, 1'b1);
      push_cell('1, TAG_IGNORED, 1'b1);
      push_cell(VALUE_W'(5), TAG_FIRST, 1'b0);
      push_cell(VALUE_W'(9), TAG_SECOND, 1'b0);
      push_cell('1, TAG_SPARE, 1'b1);
      push_cell(VALUE_W'(7), TAG_FIRST, 1'b0);
      push_cell(VALUE_W'(7), TAG_SECOND, 1'b1);
      push_cell('0, TAG_FIRST, 1'b0);
      push_cell('0, TAG_SECOND, 1'b1);
      push_cell('0, TAG_FIRST, 1'b0);
      push_cell('0, TAG_FIRST, 1'b0);
      push_cell(VALUE_W'(3), TAG_FIRST, 1'b0);
      push_cell('0, TAG_SECOND, 1'b0);
      push_cell(VALUE_W'(4), TAG_SECOND, 1'b1);
      push_cell('0, TAG_FIRST, 1'b0);
      push_cell(VALUE_W'(3), TAG_FIRST, 1'b0);
      push_cell(VALUE_W'(3), TAG_FIRST, 1'b0);
      push_cell(VALUE_W'(2), TAG_SECOND, 1'b1);
      push_cell(VALUE_W'(32'h8000_0001), TAG_SECOND, 1'b1);
      drain_rows();

      set_threshold('0);
      push_random_rows(30);
      drain_rows();

      set_threshold(CV_ONE);
      push_random_rows(80);
      pressure_armed = 1'b1;
      drain_rows();

      set_threshold('1);
      push_random_rows(30);
      drain_rows();

      // A row that overruns the column limit with full-scale sums.
      set_threshold(CV_W'($urandom_range(0, 65536)));
      for (i = 0; i < 1030; i++) begin
         if (i < 1023) push_cell('1, TAG_FIRST, 1'b0);
         else if (i == 1023) push_cell(VALUE_W'(5), TAG_SECOND, 1'b0);
         else push_cell(VALUE_W'($urandom()), (i % 2) ? TAG_SECOND : TAG_FIRST, i == 1029);
      end
      push_random_rows(20);
      drain_rows();

      no_idle = 1'b1;
      set_threshold(CV_W'($urandom_range(0, 65536)));
      push_random_rows(60);
      drain_rows();

      $display("Streamed %0d cells in %0d rows under %0d threshold settings.",
               cells_sent, rows_sent, settings_used);
      $display("Checked %0d verdicts: %0d rows kept, %0d failed the nonzero test.",
               verdicts_checked, rows_kept, rows_failed_test);
      if (mismatches == 0 && expected_verdicts.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches, %0d verdicts never arrived.",
                  mismatches, expected_verdicts.size());
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/tgcv_pkg.sv
rtl/tgcv_ctrl.sv
rtl/tgcv_datapath.sv
rtl/two_group_cv_row_filter_unit.sv
verif/two_group_cv_row_filter_unit_test.sv
